// ===== rtl/ctnms_pkg.sv =====
`default_nettype none
package ctnms_pkg;

   typedef logic [15:0] response_type;
   typedef logic [10:0] coord_type;
   typedef logic [21:0] tally_type;
   typedef logic [1:0]  csr_index_type;
   typedef logic [11:0] csr_data_type;

   // register indexes on the csr port
   localparam csr_index_type CSR_THRESHOLD    = 2'd0;
   localparam csr_index_type CSR_FRAME_WIDTH  = 2'd1;
   localparam csr_index_type CSR_FRAME_HEIGHT = 2'd2;

   localparam logic [7:0]  THRESHOLD_RESET    = 8'd100;
   localparam logic [11:0] FRAME_WIDTH_RESET  = 12'd640;
   localparam logic [11:0] FRAME_HEIGHT_RESET = 12'd480;
   localparam int unsigned MIN_SIZE           = 3;

   localparam tally_type TALLY_MAX = 22'h3F_FFFF;

endpackage
`default_nettype wire

// ===== rtl/ctnms_ram.sv =====
`default_nettype none
module ctnms_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  wire                     clock,
   input  wire                     wr_en,
   input  wire [$clog2(DEPTH)-1:0] wr_addr,
   input  wire [WIDTH-1:0]         wr_data,
   input  wire                     rd_en,
   input  wire [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // read data holds while rd_en is low
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/corner_threshold_nms_3x3.sv =====
// channel | ports                                  | dir | word
// req     | req_valid, req_stall, req_response     | in  | one pixel response, raster order
// rsp     | rsp_valid, rsp_stall, rsp_center_row.. | out | verdict for one interior pixel
// csr     | csr_wr_en, csr_index, csr_data         | in  | register write, no wait
// One pixel is taken every cycle unless req_stall is high; the verdict a pixel
// completes passes through the input stage and then the result register. The rate is
// set by the single line-store port pair: one read and one write per cycle.
// Reset is synchronous; the line store needs no clearing pass, a fill count masks
// columns not yet written so they read as zero.
// rsp_stall holds the result register and, when a new verdict is due, req_stall rises.
`default_nettype none
module corner_threshold_nms_3x3 #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_stall,
   input  wire ctnms_pkg::response_type req_response,
   output logic                     rsp_valid,
   input  wire                      rsp_stall,
   output ctnms_pkg::coord_type     rsp_center_row,
   output ctnms_pkg::coord_type     rsp_center_col,
   output logic                     rsp_is_corner,
   output ctnms_pkg::tally_type     rsp_corner_total,
   output logic                     rsp_frame_last,
   input  wire                      csr_wr_en,
   input  wire ctnms_pkg::csr_index_type csr_index,
   input  wire ctnms_pkg::csr_data_type  csr_data
);
   import ctnms_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int FW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);

   // configuration
   logic [7:0]  threshold_ff;
   logic [11:0] frame_width_ff, frame_height_ff;
   logic [FW-1:0] width_eff;
   logic [HW-1:0] height_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff    <= THRESHOLD_RESET;
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_THRESHOLD:    threshold_ff    <= csr_data[7:0];
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_data;
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      priority if (32'(frame_width_ff) < MIN_SIZE) width_eff = FW'(MIN_SIZE);
      else if (32'(frame_width_ff) > MAX_WIDTH)   width_eff = FW'(MAX_WIDTH);
      else                                        width_eff = FW'(frame_width_ff);
      priority if (32'(frame_height_ff) < MIN_SIZE) height_eff = HW'(MIN_SIZE);
      else if (32'(frame_height_ff) > MAX_HEIGHT)  height_eff = HW'(MAX_HEIGHT);
      else                                         height_eff = HW'(frame_height_ff);
   end

   // position counters, advanced as each word is taken
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic          accept, row_end, frame_end;

   assign accept    = req_valid & ~req_stall;
   assign row_end   = (32'(col_ff) + 32'd1) >= 32'(width_eff);
   assign frame_end = row_end && ((32'(row_ff) + 32'd1) >= 32'(height_eff));

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (row_end) begin
            col_in = '0;
            row_in = frame_end ? '0 : row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   // input stage: pixel waits here while the line store is read
   logic          a_valid_ff, a_valid_in;
   response_type  a_px_ff;
   logic [CW-1:0] a_col_ff;
   logic [RW-1:0] a_row_ff;
   logic          a_judged_ff, a_last_ff;
   logic          a_adv;

   // line store word: older line in the upper half, newer line in the lower
   logic [31:0]   ram_rd_data;
   logic [FW-1:0] fill_ff, fill_in;
   logic          line_ok;
   response_type  top, mid, centre;
   response_type  win_ff [6];
   response_type  nbr [9];
   logic          corner;
   tally_type     tally_ff, tally_in, tally_bumped;

   assign a_adv      = a_valid_ff & (~a_judged_ff | ~rsp_valid | ~rsp_stall);
   assign req_stall  = a_valid_ff & ~a_adv;
   assign a_valid_in = accept | (a_valid_ff & ~a_adv);

   ctnms_ram #(
      .WIDTH(32),
      .DEPTH(MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (a_adv),
      .wr_addr (a_col_ff),
      .wr_data ({mid, a_px_ff}),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (ram_rd_data)
   );

   // columns are always written from zero upwards, so the written set is a prefix
   assign line_ok = FW'(a_col_ff) < fill_ff;
   assign top     = line_ok ? ram_rd_data[31:16] : '0;
   assign mid     = line_ok ? ram_rd_data[15:0]  : '0;

   always_comb begin
      fill_in = fill_ff;
      if (a_adv && (FW'(a_col_ff) + FW'(1)) > fill_ff) begin
         fill_in = FW'(a_col_ff) + FW'(1);
      end
   end

   assign nbr[0] = win_ff[0];
   assign nbr[1] = win_ff[3];
   assign nbr[2] = top;
   assign nbr[3] = win_ff[1];
   assign nbr[4] = win_ff[4];
   assign nbr[5] = mid;
   assign nbr[6] = win_ff[2];
   assign nbr[7] = win_ff[5];
   assign nbr[8] = a_px_ff;
   assign centre = nbr[4];

   // ties with the centre do not suppress
   always_comb begin
      corner = centre > {threshold_ff, 8'h00};
      for (int k = 0; k < 9; k++) begin
         if (nbr[k] > centre) corner = 1'b0;
      end
   end

   assign tally_bumped = (corner && tally_ff < TALLY_MAX) ? tally_ff + 22'd1 : tally_ff;

   always_comb begin
      tally_in = tally_ff;
      if (a_adv) begin
         if (a_last_ff)        tally_in = '0;
         else if (a_judged_ff) tally_in = tally_bumped;
      end
   end

   // result register
   logic rsp_valid_ff, rsp_valid_in;
   assign rsp_valid_in = (a_adv & a_judged_ff) | (rsp_valid_ff & rsp_stall);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         a_valid_ff   <= 1'b0;
         fill_ff      <= '0;
         tally_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 6; i++) win_ff[i] <= '0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         a_valid_ff   <= a_valid_in;
         fill_ff      <= fill_in;
         tally_ff     <= tally_in;
         rsp_valid_ff <= rsp_valid_in;
         if (a_adv) begin
            win_ff[0] <= win_ff[3];
            win_ff[1] <= win_ff[4];
            win_ff[2] <= win_ff[5];
            win_ff[3] <= top;
            win_ff[4] <= mid;
            win_ff[5] <= a_px_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_px_ff     <= req_response;
         a_col_ff    <= col_ff;
         a_row_ff    <= row_ff;
         a_judged_ff <= (32'(row_ff) >= 32'd2) && (32'(col_ff) >= 32'd2);
         a_last_ff   <= frame_end;
      end
      if (a_adv && a_judged_ff) begin
         rsp_center_row   <= 11'(a_row_ff - RW'(1));
         rsp_center_col   <= 11'(a_col_ff - CW'(1));
         rsp_is_corner    <= corner;
         rsp_corner_total <= tally_bumped;
         rsp_frame_last   <= a_last_ff;
      end
   end

   // checks
   a_fill_bound : assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) <= MAX_WIDTH)
      else $error("fill count beyond line store depth");

   a_col_bound : assert property (@(posedge clock) disable iff (reset)
      32'(col_ff) < MAX_WIDTH)
      else $error("column counter beyond line store depth");

   a_corner_counted : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_corner) |-> (rsp_corner_total != '0))
      else $error("corner reported with zero total");

   a_rsp_source : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(a_adv && a_judged_ff))
      else $error("result word raised without a judged pixel");

   a_stall_source : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (a_valid_ff && a_judged_ff && rsp_valid_ff && rsp_stall))
      else $error("input stalled without a blocked result");

endmodule
`default_nettype wire
